>>> rtl/ssca_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssca_pkg: shared types and constants of the slab size-class allocator
// Status codes, class limits and the controller-to-datapath command word.
// ----------------------------------------------------------------------------
package ssca_pkg;

	localparam int NUM_CLASSES = 9;
	localparam int MIN_OBJ     = 8;
	localparam int MAX_OBJ     = 2048;
	localparam int LINK_BYTES  = 4;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_FALLBACK  = 3'd1;
	localparam logic [2:0] ST_NO_SLAB   = 3'd2;
	localparam logic [2:0] ST_BAD_SIZE  = 3'd3;
	localparam logic [2:0] ST_NOT_FOUND = 3'd4;

	// Controller commands to the datapath.
	typedef struct packed {
		logic load;      // capture request word
		logic open_slab; // open the slab: write head/count/colour
		logic chain_wr;  // write one chain link
		logic scan_rd;   // evaluate current scanned slab
		logic link_rd;   // latch the object address of the hit
		logic pop;       // commit pop with link data
		logic push;      // commit push
		logic done;      // result ready to register
	} ssca_cmd_t;

	// Datapath status to the controller.
	typedef struct packed {
		logic       is_free;
		logic       addr_zero;
		logic       size_fallback;
		logic       size_bad;
		logic       class_empty;
		logic       no_slab;
		logic       chain_last;
		logic       scan_end;
		logic       scan_hit;
		logic       push_ok;
	} ssca_stat_t;

	// Smallest class whose object holds the size; NUM_CLASSES if none.
	function automatic logic [3:0] class_of(input logic [15:0] sz);
		logic [3:0] c;
		c = 4'(NUM_CLASSES);
		for (int i = NUM_CLASSES - 1; i >= 0; i--)
			if (sz <= 16'(MIN_OBJ << i)) c = 4'(i);
		return c;
	endfunction

endpackage

>>> rtl/ssca_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssca_ram: generic single-port RAM
// One address per cycle, read always, written on we; registered read data.
// ----------------------------------------------------------------------------
module ssca_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end
endmodule

>>> rtl/ssca_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssca_datapath: per-slab tables, link memory and address arithmetic
// Scans one slab per cycle; chains one link per cycle on slab open.
// ----------------------------------------------------------------------------
module ssca_datapath #(
	parameter int SLAB_BYTES   = 4096,
	parameter int HEADER_BYTES = 32,
	parameter int MAX_SLABS    = 8,
	parameter int MAX_OBJECTS  = 512
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [31:0]         region_base,
	input  logic                mode,
	input  logic [15:0]         size,
	input  logic [31:0]         address,
	input  ssca_pkg::ssca_cmd_t cmd,
	output ssca_pkg::ssca_stat_t stat,
	output logic [2:0]          res_status,
	output logic [31:0]         res_addr,
	output logic [3:0]          res_class
);
	localparam int NC    = ssca_pkg::NUM_CLASSES;
	localparam int SLOTS = NC * MAX_SLABS;
	localparam int SW    = $clog2(SLOTS);
	localparam int SLW   = $clog2(MAX_SLABS + 1);
	localparam int OW    = $clog2(MAX_OBJECTS);
	localparam int CW    = $clog2(MAX_OBJECTS + 1);
	localparam int TW    = $clog2(MAX_SLABS * MAX_OBJECTS + 1);
	localparam int LW    = $clog2(SLOTS * MAX_OBJECTS);
	localparam int USE   = SLAB_BYTES - HEADER_BYTES;
	localparam int SWW   = OW + CW + 12;

	// request word
	logic        mode_q;
	logic [15:0] size_q;
	logic [31:0] addr_q;
	logic [3:0]  cls_q;

	// per-class state
	logic [SLW-1:0] inuse_q  [NC];
	logic [TW-1:0]  total_q  [NC];
	logic [11:0]    ncol_q   [NC];

	logic [SLW-1:0] s_q;      // scanned slab
	logic [SLW-1:0] s_nx;
	logic [OW-1:0]  ci_q;     // chain index
	logic [31:0]    obj_q;

	logic [3:0]     cls_c;
	logic [3:0]     ci;       // clipped class index
	logic [CW-1:0]  n_c;
	logic [11:0]    span_c;
	logic [11:0]    nc_nx;
	logic [CW-1:0]  n_tab    [NC];
	logic [11:0]    span_tab [NC];
	logic [SW-1:0]  slot_c, open_slot_c;
	logic [31:0]    page_c, first_c, off_c, rel_c;
	logic [OW-1:0]  hidx_c;

	// slot word memory: head, free count and colour per slab
	logic           swe;
	logic [SW-1:0]  saddr;
	logic [SWW-1:0] swdata, srd;
	logic [OW-1:0]  head_c;
	logic [CW-1:0]  cnt_c;
	logic [11:0]    col_c;

	// link memory
	logic           lwe;
	logic [LW-1:0]  laddr;
	logic [OW-1:0]  lwdata, lrdata;

	// objects per slab and colour span of each class
	for (genvar g = 0; g < NC; g++) begin : g_class
		localparam int OBJ_B = ssca_pkg::MIN_OBJ << g;
		localparam int FIT   = USE / (OBJ_B + ssca_pkg::LINK_BYTES);
		localparam int SPAN  = USE % (OBJ_B + ssca_pkg::LINK_BYTES);
		assign n_tab[g]    = CW'((FIT > MAX_OBJECTS) ? MAX_OBJECTS : FIT);
		assign span_tab[g] = 12'(SPAN);
	end

	assign cls_c = ssca_pkg::class_of(size_q);
	assign ci    = (cls_q < 4'(NC)) ? cls_q : 4'd0;

	always_comb begin
		n_c = '0;
		span_c = '0;
		for (int c = 0; c < NC; c++)
			if (ci == 4'(c)) begin
				n_c = n_tab[c];
				span_c = span_tab[c];
			end
	end

	assign head_c = srd[SWW-1 -: OW];
	assign cnt_c  = srd[12 +: CW];
	assign col_c  = srd[11:0];

	assign nc_nx = (ncol_q[ci] == 12'hFFF || ncol_q[ci] >= span_c) ? 12'd0
	               : ncol_q[ci] + 12'd1;

	assign slot_c      = SW'(ci * MAX_SLABS) + SW'(s_q);
	assign open_slot_c = SW'(ci * MAX_SLABS) + SW'(inuse_q[ci]);
	assign page_c  = region_base + 32'(slot_c) * 32'(SLAB_BYTES);
	assign first_c = 32'(HEADER_BYTES) + 32'(n_c) * 32'(ssca_pkg::LINK_BYTES) + 32'(col_c);
	assign off_c   = addr_q - page_c;
	assign rel_c   = (off_c - first_c) >> (ci + 4'd3);
	assign hidx_c  = head_c;

	// status to controller
	always_comb begin
		stat.is_free       = mode_q;
		stat.addr_zero     = (addr_q == '0);
		stat.size_fallback = (size_q < 16'(ssca_pkg::MIN_OBJ)) || (size_q > 16'(ssca_pkg::MAX_OBJ));
		stat.size_bad      = (size_q > 16'(ssca_pkg::MAX_OBJ));
		stat.class_empty   = (total_q[ci] == '0);
		stat.no_slab       = (inuse_q[ci] >= SLW'(MAX_SLABS)) || (n_c == '0);
		stat.chain_last    = (CW'(ci_q) + CW'(1) >= n_c);
		stat.scan_end      = (s_q >= inuse_q[ci]);
		stat.scan_hit      = mode_q ? ((off_c < 32'(SLAB_BYTES)) && (off_c >= first_c))
		                            : (cnt_c != '0);
		stat.push_ok       = (rel_c < 32'(n_c)) && (cnt_c < n_c);
	end

	// next scanned slab; its slot word is read in the cycle before it is scanned
	assign s_nx = (cmd.scan_rd && !stat.scan_hit) ? s_q + SLW'(1) : s_q;

	// slot word memory port select
	always_comb begin
		swe    = 1'b0;
		saddr  = SW'(ci * MAX_SLABS) + SW'(s_nx);
		swdata = srd;
		if (cmd.open_slab) begin
			swe    = 1'b1;
			saddr  = open_slot_c;
			swdata = {OW'(0), n_c, nc_nx};
		end else if (cmd.pop) begin
			swe    = 1'b1;
			saddr  = slot_c;
			swdata = {lrdata, cnt_c - CW'(1), col_c};
		end else if (cmd.push) begin
			swe    = 1'b1;
			saddr  = slot_c;
			swdata = {rel_c[OW-1:0], cnt_c + CW'(1), col_c};
		end
	end

	ssca_ram #(.WIDTH(SWW), .DEPTH(SLOTS)) u_slots (
		.clk(clk), .we(swe), .addr(saddr), .wdata(swdata), .rdata(srd)
	);

	// link memory port select
	always_comb begin
		lwe    = 1'b0;
		laddr  = LW'(slot_c) * LW'(MAX_OBJECTS) + LW'(hidx_c);
		lwdata = head_c;
		if (cmd.chain_wr) begin
			lwe    = 1'b1;
			laddr  = LW'(open_slot_c) * LW'(MAX_OBJECTS) + LW'(ci_q);
			lwdata = stat.chain_last ? '0 : ci_q + OW'(1);
		end else if (cmd.push) begin
			lwe    = 1'b1;
			laddr  = LW'(slot_c) * LW'(MAX_OBJECTS) + LW'(rel_c[OW-1:0]);
		end
	end

	ssca_ram #(.WIDTH(OW), .DEPTH(SLOTS * MAX_OBJECTS)) u_links (
		.clk(clk), .we(lwe), .addr(laddr), .wdata(lwdata), .rdata(lrdata)
	);

	// request capture and scan pointers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= mode;
			size_q <= size;
			addr_q <= address;
			s_q    <= '0;
			ci_q   <= '0;
		end else begin
			if (cmd.chain_wr) ci_q <= ci_q + OW'(1);
			s_q <= s_nx;
			if (cmd.link_rd)
				obj_q <= page_c + first_c + (32'(hidx_c) << (ci + 4'd3));
		end
		if (cmd.load) cls_q <= 4'd0;
		else if (cmd.open_slab == 1'b0 && !cmd.done && !cmd.chain_wr && !cmd.scan_rd
		         && !cmd.link_rd && !cmd.pop && !cmd.push && size_q != 16'hFFFF)
			cls_q <= cls_c;
	end

	// per-class state updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NC; c++) begin
				inuse_q[c] <= '0;
				total_q[c] <= '0;
				ncol_q[c]  <= '1;
			end
		end else if (cmd.open_slab) begin
			total_q[ci] <= total_q[ci] + TW'(n_c);
			inuse_q[ci] <= inuse_q[ci] + SLW'(1);
			ncol_q[ci]  <= nc_nx;
		end else if (cmd.pop) begin
			total_q[ci] <= total_q[ci] - TW'(1);
		end else if (cmd.push) begin
			total_q[ci] <= total_q[ci] + TW'(1);
		end
	end

	// result selection
	always_comb begin
		res_class  = ci;
		res_addr   = '0;
		res_status = ssca_pkg::ST_OK;
		if (!mode_q) begin
			if (stat.size_fallback) begin
				res_status = ssca_pkg::ST_FALLBACK;
				res_class  = '0;
			end else if (cmd.pop) begin
				res_addr = obj_q;
			end else res_status = ssca_pkg::ST_NO_SLAB;
		end else if (stat.addr_zero) begin
			res_class = '0;
		end else if (stat.size_bad) begin
			res_status = ssca_pkg::ST_BAD_SIZE;
			res_class  = '0;
		end else if (!cmd.push) res_status = ssca_pkg::ST_NOT_FOUND;
	end
endmodule

>>> rtl/ssca_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssca_ctrl: request sequencer
// Steps through decode, chaining and slab open, scan and commit per request.
// ----------------------------------------------------------------------------
module ssca_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 out_full,
	input  ssca_pkg::ssca_stat_t stat,
	output ssca_pkg::ssca_cmd_t  cmd
);
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_DEC   = 3'd1;
	localparam logic [2:0] S_CHAIN = 3'd2;
	localparam logic [2:0] S_SCAN  = 3'd3;
	localparam logic [2:0] S_LINK  = 3'd4;
	localparam logic [2:0] S_POP   = 3'd5;
	localparam logic [2:0] S_CLS   = 3'd6;
	localparam logic [2:0] S_FETCH = 3'd7;

	logic [2:0] state_q, state_d;

	assign in_stall = (state_q != S_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CLS;
				end
			end
			S_CLS: state_d = S_DEC;
			S_DEC: begin
				if (!out_full) begin
					if (!stat.is_free) begin
						if (stat.size_fallback) begin
							cmd.done = 1'b1;
							state_d  = S_IDLE;
						end else if (stat.class_empty) begin
							if (stat.no_slab) begin
								cmd.done = 1'b1;
								state_d  = S_IDLE;
							end else state_d = S_CHAIN;
						end else state_d = S_SCAN;
					end else if (stat.addr_zero || stat.size_bad) begin
						cmd.done = 1'b1;
						state_d  = S_IDLE;
					end else state_d = S_SCAN;
				end
			end
			S_CHAIN: begin
				cmd.chain_wr = 1'b1;
				if (stat.chain_last) begin
					cmd.open_slab = 1'b1;
					state_d = S_FETCH;
				end
			end
			// reread the first slot word after the slab open
			S_FETCH: state_d = S_SCAN;
			S_SCAN: begin
				if (stat.scan_end) begin
					cmd.done = 1'b1;
					state_d  = S_IDLE;
				end else begin
					cmd.scan_rd = 1'b1;
					if (stat.scan_hit) begin
						if (stat.is_free) begin
							cmd.done = 1'b1;
							cmd.push = stat.push_ok;
							state_d  = S_IDLE;
						end else begin
							cmd.link_rd = 1'b1;
							state_d = S_LINK;
						end
					end
				end
			end
			S_LINK: state_d = S_POP;
			S_POP: begin
				cmd.pop  = 1'b1;
				cmd.done = 1'b1;
				state_d  = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end
endmodule

>>> rtl/slab_size_class_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slab_size_class_allocator: power-of-two slab allocator with colouring
// Top level: controller, datapath and output word register.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel (in_valid/in_stall) carries one request word: mode, size,
//  address. Output channel (out_valid/out_stall) returns one result word.
//  One request is in work at a time; the next word is taken the cycle after
//  the result is in the output register, even while it waits to be taken.
//  Steps: the word is taken in idle, its class is latched, then decode.
//  A reject, a free of address zero or an allocation with no slab left
//  ends in decode. A free scans the open slabs, one slab a cycle, and
//  pushes on a valid hit or ends at the last slab; an allocation scans
//  the same way, then reads the link and pops. Opening a slab first
//  writes the links, one link a cycle, then rereads the first slot word.
//  The link and slot memories each have a single port.
//  A stalled output word holds; the controller waits in decode until the
//  output register is free.
//  Reset zeroes per-class slab use and free totals, sets colours to ones; slot
//  words and links are written at slab open; cfg_we writes region_base.
// ----------------------------------------------------------------------------
module slab_size_class_allocator #(
	parameter int SLAB_BYTES   = 4096,
	parameter int HEADER_BYTES = 32,
	parameter int MAX_SLABS    = 8,
	parameter int MAX_OBJECTS  = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        mode,
	input  logic [15:0] size,
	input  logic [31:0] address,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [31:0] object_address,
	output logic [3:0]  size_class
);
	ssca_pkg::ssca_cmd_t  cmd;
	ssca_pkg::ssca_stat_t stat;
	logic [31:0] region_base_q;
	logic [2:0]  rs;
	logic [31:0] ra;
	logic [3:0]  rc;
	logic        full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) region_base_q <= '0;
		else if (cfg_we) region_base_q <= cfg_wdata;
	end

	assign full = out_valid && out_stall;

	ssca_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_full(full), .stat(stat), .cmd(cmd)
	);

	ssca_datapath #(
		.SLAB_BYTES(SLAB_BYTES), .HEADER_BYTES(HEADER_BYTES),
		.MAX_SLABS(MAX_SLABS), .MAX_OBJECTS(MAX_OBJECTS)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .region_base(region_base_q),
		.mode(mode), .size(size), .address(address), .cmd(cmd), .stat(stat),
		.res_status(rs), .res_addr(ra), .res_class(rc)
	);

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (cmd.done) out_valid <= 1'b1;
		else if (!out_stall) out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.done) begin
			status         <= rs;
			object_address <= ra;
			size_class     <= rc;
		end
	end
endmodule
